[rtl/gaic_pkg.sv]
package gaic_pkg;

    localparam int RATE_W    = 16;
    localparam int SCALE_W   = 32;
    localparam int ANG_W     = 48;
    localparam int INC_W     = 49;
    localparam int DRF_W     = 56;
    localparam int SUM_W     = 58;
    localparam int OUT_W     = 32;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int DIV_PH_W  = $clog2(DIV_STEPS);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1501500;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Angles are signed Q16.32 degrees.
    localparam logic signed [ANG_W-1:0] DEG180 = 48'sh00B4_0000_0000;
    localparam logic signed [ANG_W-1:0] DEG360 = 48'sh0168_0000_0000;

    localparam logic signed [SUM_W-1:0] ANG_HI = (58'sd1 <<< (ANG_W - 1)) - 58'sd1;
    localparam logic signed [SUM_W-1:0] ANG_LO = -(58'sd1 <<< (ANG_W - 1));
    localparam logic signed [SUM_W-1:0] DRF_HI = (58'sd1 <<< (DRF_W - 1)) - 58'sd1;
    localparam logic signed [SUM_W-1:0] DRF_LO = -(58'sd1 <<< (DRF_W - 1));

    typedef enum logic [1:0] {
        MODE_RESTART,
        MODE_CAL_SUM,
        MODE_CAL_END,
        MODE_RUN
    } t_mode;

    typedef struct packed {
        logic                advance;
        t_mode               mode;
        logic                div_step;
        logic                div_commit;
        logic [DIV_PH_W-1:0] div_phase;
    } t_lane_ctl;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > ANG_HI) begin
            c = ANG_HI;
        end else if (v < ANG_LO) begin
            c = ANG_LO;
        end
        return c[ANG_W-1:0];
    endfunction

    function automatic logic signed [DRF_W-1:0] sat_drf(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > DRF_HI) begin
            c = DRF_HI;
        end else if (v < DRF_LO) begin
            c = DRF_LO;
        end
        return c[DRF_W-1:0];
    endfunction

endpackage

[rtl/gyro_angle_integrator_with_bias_cal.sv]
// Channel   Direction  Ports                         Contents
// s         in         i_s_tvalid/o_s_tready         tdata: rate_x, rate_y, rate_z; tuser: cmd
// m         out        o_m_tvalid/i_m_tready         tdata: angle_x, angle_y, angle_z;
//                                                    tuser: calibrating
// cfg       in         i_cfg_valid/o_cfg_ready       scale_factor
//
// One word per cycle while the output is free and no drift division runs; each word passes
// the multiply stage, then the angle update into the output register.
// The word that ends calibration starts a four-step reciprocal multiply in every lane
// and a commit cycle; the next word waits in the input stage meanwhile.
// Synchronous active-low reset: angles, references and drifts cleared, calibration running.
// Output backpressure stalls both stages; the input stage still fills while the result waits.
module gyro_angle_integrator_with_bias_cal #(
    parameter int unsigned CAL_SAMPLES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [3*gaic_pkg::RATE_W-1:0]     i_s_tdata,   // rate_x, rate_y, rate_z
    input  logic                              i_s_tuser,   // cmd
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [3*gaic_pkg::OUT_W-1:0]      o_m_tdata,   // angle_x, angle_y, angle_z
    output logic                              o_m_tuser,   // calibrating
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gaic_pkg::SCALE_W-1:0]      i_cfg_data
);
    import gaic_pkg::*;

    localparam int CW = $clog2(CAL_SAMPLES + 1);

    logic [SCALE_W-1:0]   r_scale;
    logic                 r_a_valid, n_a_valid;
    logic                 r_a_cmd;
    logic                 r_cal_active, n_cal_active;
    logic [CW-1:0]        r_cal_cnt, n_cal_cnt;
    logic                 r_div_busy, n_div_busy;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    logic                 w_load, w_advance, w_out_free;
    t_mode                w_mode;
    t_lane_ctl            w_ctl;
    logic                 w_cal_flag;
    logic signed [ANG_W-1:0] w_ang_x, w_ang_y, w_ang_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    assign w_advance  = r_a_valid && w_out_free && !r_div_busy;
    assign o_s_tready = !r_a_valid || w_advance;
    assign w_load     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_a_cmd == CMD_RESTART) begin
            w_mode = MODE_RESTART;
        end else if (r_cal_active && (r_cal_cnt < CW'(CAL_SAMPLES))) begin
            w_mode = MODE_CAL_SUM;
        end else if (r_cal_active) begin
            w_mode = MODE_CAL_END;
        end else begin
            w_mode = MODE_RUN;
        end
    end

    always_comb begin
        n_a_valid    = r_a_valid;
        n_cal_active = r_cal_active;
        n_cal_cnt    = r_cal_cnt;
        n_div_busy   = r_div_busy;
        n_div_cnt    = r_div_cnt;
        if (w_load) begin
            n_a_valid = 1'b1;
        end else if (w_advance) begin
            n_a_valid = 1'b0;
        end
        if (r_div_busy) begin
            if (r_div_cnt == DIV_CNT_W'(DIV_STEPS)) begin
                n_div_busy = 1'b0;
            end else begin
                n_div_cnt = r_div_cnt + 1'b1;
            end
        end
        if (w_advance) begin
            unique case (w_mode)
                MODE_RESTART: begin
                    n_cal_active = 1'b1;
                    n_cal_cnt    = '0;
                end
                MODE_CAL_SUM: begin
                    n_cal_cnt = r_cal_cnt + 1'b1;
                end
                MODE_CAL_END: begin
                    n_cal_active = 1'b0;
                    n_cal_cnt    = '0;
                    n_div_busy   = 1'b1;
                    n_div_cnt    = '0;
                end
                MODE_RUN: begin
                    n_cal_active = 1'b0;
                end
                default: begin
                    n_cal_active = r_cal_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_cal_active <= 1'b1;
            r_cal_cnt    <= '0;
            r_div_busy   <= 1'b0;
            r_div_cnt    <= '0;
        end else begin
            r_a_valid    <= n_a_valid;
            r_cal_active <= n_cal_active;
            r_cal_cnt    <= n_cal_cnt;
            r_div_busy   <= n_div_busy;
            r_div_cnt    <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_a_cmd <= i_s_tuser;
        end
    end

    assign w_ctl.advance    = w_advance;
    assign w_ctl.mode       = w_mode;
    assign w_ctl.div_step   = r_div_busy && (r_div_cnt != DIV_CNT_W'(DIV_STEPS));
    assign w_ctl.div_commit = r_div_busy && (r_div_cnt == DIV_CNT_W'(DIV_STEPS));
    assign w_ctl.div_phase  = r_div_cnt[DIV_PH_W-1:0];

    assign w_cal_flag = n_cal_active;

    gaic_lane #(.CAL_SAMPLES(CAL_SAMPLES), .HEADING(1'b0)) u_lane_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_rate       ($signed(i_s_tdata[RATE_W-1:0])),
        .i_scale      (r_scale),
        .i_ctl        (w_ctl),
        .o_next_angle (w_ang_x)
    );

    gaic_lane #(.CAL_SAMPLES(CAL_SAMPLES), .HEADING(1'b0)) u_lane_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_rate       ($signed(i_s_tdata[2*RATE_W-1:RATE_W])),
        .i_scale      (r_scale),
        .i_ctl        (w_ctl),
        .o_next_angle (w_ang_y)
    );

    gaic_lane #(.CAL_SAMPLES(CAL_SAMPLES), .HEADING(1'b1)) u_lane_z (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_rate       ($signed(i_s_tdata[3*RATE_W-1:2*RATE_W])),
        .i_scale      (r_scale),
        .i_ctl        (w_ctl),
        .o_next_angle (w_ang_z)
    );

    gaic_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance),
        .i_angle_x  (w_ang_x),
        .i_angle_y  (w_ang_y),
        .i_angle_z  (w_ang_z),
        .i_cal      (w_cal_flag),
        .o_free     (w_out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_no_update_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !w_advance)
        else $error("angle update during drift division");

    a_count_idle_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal_active |-> (r_cal_cnt == '0))
        else $error("calibration count nonzero outside calibration");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_cnt <= CW'(CAL_SAMPLES))
        else $error("calibration count past sample total");

    a_end_starts_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (w_mode == MODE_CAL_END)) |=> r_div_busy)
        else $error("calibration end did not start drift division");
`endif

endmodule

[rtl/gaic_lane.sv]
module gaic_lane #(
    parameter int unsigned CAL_SAMPLES = 256,
    parameter bit          HEADING     = 1'b0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [gaic_pkg::RATE_W-1:0]   i_rate,
    input  logic        [gaic_pkg::SCALE_W-1:0]  i_scale,
    input  gaic_pkg::t_lane_ctl                  i_ctl,
    output logic signed [gaic_pkg::ANG_W-1:0]    o_next_angle
);
    import gaic_pkg::*;

    // Reciprocal of CAL_SAMPLES, rounded up, scaled so that the top bits of
    // magnitude times reciprocal give the exact truncated quotient.
    localparam int DIV_SH = $clog2(CAL_SAMPLES);
    localparam int RCP_W  = DRF_W + 2;
    localparam int RLO_W  = RCP_W / 2;
    localparam int MLO_W  = DRF_W / 2;
    localparam int PP_W   = MLO_W + RLO_W;
    localparam int PROD_W = DRF_W + RCP_W;
    localparam logic [PROD_W-1:0] RECIP_FULL =
        ((PROD_W'(1) << (DRF_W + DIV_SH)) + PROD_W'(CAL_SAMPLES - 1)) / PROD_W'(CAL_SAMPLES);
    localparam logic [RCP_W-1:0] RECIP = RECIP_FULL[RCP_W-1:0];

    logic signed [INC_W-1:0] w_prod;
    logic signed [INC_W-1:0] r_inc;

    logic signed [ANG_W-1:0] r_angle, n_angle;
    logic signed [ANG_W-1:0] r_ref, n_ref;
    logic signed [DRF_W-1:0] r_drift, n_drift;

    logic signed [ANG_W-1:0] w_a1, w_a2, w_a2w;
    logic signed [DRF_W-1:0] w_sum;
    logic        [DRF_W-1:0] w_mag;

    logic [DRF_W-1:0]  r_mag;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;
    logic [MLO_W-1:0]  w_mag_part;
    logic [RLO_W-1:0]  w_rcp_part;
    logic [PP_W-1:0]   w_part;
    logic [PROD_W-1:0] w_addend;
    logic [DRF_W-1:0]  w_quot;

    // Heading lane integrates the negated rate.
    assign w_prod = i_rate * $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_inc <= HEADING ? -w_prod : w_prod;
        end
    end

    assign w_a1  = sat_ang(SUM_W'(r_angle) + SUM_W'(r_inc));
    assign w_sum = sat_drf(SUM_W'(r_drift) + (SUM_W'(w_a1) - SUM_W'(r_ref)));
    assign w_a2  = sat_ang(SUM_W'(w_a1) - SUM_W'(r_drift));

    always_comb begin
        w_a2w = w_a2;
        if (HEADING) begin
            if (w_a2 > DEG180) begin
                w_a2w = w_a2 - DEG360;
            end else if (w_a2 < -DEG180) begin
                w_a2w = w_a2 + DEG360;
            end
        end
    end

    always_comb begin
        n_angle = r_angle;
        n_ref   = r_ref;
        n_drift = r_drift;
        unique case (i_ctl.mode)
            MODE_RESTART: begin
                n_ref   = r_angle;
                n_drift = '0;
            end
            MODE_CAL_SUM: begin
                n_angle = w_a1;
                n_ref   = w_a1;
                n_drift = w_sum;
            end
            MODE_CAL_END: begin
                n_angle = w_a2;
            end
            MODE_RUN: begin
                n_angle = w_a2w;
            end
            default: begin
                n_angle = r_angle;
            end
        endcase
    end

    assign o_next_angle = n_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_ref   <= '0;
            r_drift <= '0;
        end else if (i_ctl.div_commit) begin
            r_drift <= r_neg ? -$signed(w_quot) : $signed(w_quot);
        end else if (i_ctl.advance) begin
            r_angle <= n_angle;
            r_ref   <= n_ref;
            r_drift <= n_drift;
        end
    end

    // The drift sum magnitude is multiplied by the reciprocal one half by half
    // partial product per cycle; the phase picks the halves and their weight.
    assign w_mag      = r_drift[DRF_W-1] ? DRF_W'(-r_drift) : r_drift;
    assign w_mag_part = i_ctl.div_phase[1] ? r_mag[DRF_W-1:MLO_W] : r_mag[MLO_W-1:0];
    assign w_rcp_part = i_ctl.div_phase[0] ? RECIP[RCP_W-1:RLO_W] : RECIP[RLO_W-1:0];
    assign w_part     = PP_W'(w_mag_part) * PP_W'(w_rcp_part);
    assign w_addend   = (PROD_W'(w_part) << (i_ctl.div_phase[1] ? MLO_W : 0))
                        << (i_ctl.div_phase[0] ? RLO_W : 0);
    assign w_quot     = DRF_W'(r_acc >> (DRF_W + DIV_SH));

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && (i_ctl.mode == MODE_CAL_END)) begin
            r_mag <= w_mag;
            r_neg <= r_drift[DRF_W-1];
            r_acc <= '0;
        end else if (i_ctl.div_step) begin
            r_acc <= r_acc + w_addend;
        end
    end

endmodule

[rtl/gaic_merge.sv]
module gaic_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic signed [gaic_pkg::ANG_W-1:0]  i_angle_x,
    input  logic signed [gaic_pkg::ANG_W-1:0]  i_angle_y,
    input  logic signed [gaic_pkg::ANG_W-1:0]  i_angle_z,
    input  logic                               i_cal,
    output logic                               o_free,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [3*gaic_pkg::OUT_W-1:0]       o_m_tdata,
    output logic                               o_m_tuser
);
    import gaic_pkg::*;

    logic                   r_valid;
    logic [3*OUT_W-1:0]     r_data;
    logic                   r_cal;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Q16.32 to Q16.16 by flooring: drop the low 16 fraction bits.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= {i_angle_z[ANG_W-1:16], i_angle_y[ANG_W-1:16], i_angle_x[ANG_W-1:16]};
            r_cal  <= i_cal;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_cal;

endmodule
